>>> src/mi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mi_pkg
// Types, codes and saturating helpers for the Moran's I statistic block.
// ----------------------------------------------------------------------------
package mi_pkg;

  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_WEIGHT = 1'b1;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_ZERO_DEN = 2'd1;
  localparam logic [1:0] STATUS_COUNT    = 2'd2;

  typedef struct packed {
    logic               command;
    logic signed [31:0] sample_value;
    logic [9:0]         row_index;
    logic [9:0]         col_index;
    logic               last;
  } item_in_t;

  typedef struct packed {
    logic signed [31:0] statistic;
    logic [1:0]         status;
  } item_out_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_MEAN_DIV,
    S_MEAN_SET,
    S_SQ_RD,
    S_SQ_DEV,
    S_SQ_MUL,
    S_SQ_ACC,
    S_W_CHK,
    S_W_RDI,
    S_W_RDJ,
    S_W_T,
    S_W_MUL2,
    S_W_ACC,
    S_FIN_MUL,
    S_FIN_CHK,
    S_FIN_DIV,
    S_OUT
  } state_t;

  function automatic logic [31:0] sat32(input logic [63:0] x);
    if (x[63:31] == '0 || x[63:31] == '1) return x[31:0];
    return x[63] ? 32'h8000_0000 : 32'h7FFF_FFFF;
  endfunction

  function automatic logic [63:0] sat_add64(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) return s[64] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
    return s[63:0];
  endfunction

  // store value minus mean, saturated to 32 bits
  function automatic logic [31:0] deviate(input logic [31:0] x, input logic [31:0] m);
    logic [32:0] d;
    d = {x[31], x} - {m[31], m};
    if (d[32] != d[31]) return d[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    return d[31:0];
  endfunction

  function automatic logic [63:0] mag64(input logic [63:0] x);
    return x[63] ? 64'(64'd0 - x) : x;
  endfunction

  // apply sign to a magnitude quotient and saturate to signed 32 bits
  function automatic logic [31:0] sign_sat(input logic [127:0] q, input logic neg);
    if (neg) return (q > 128'h8000_0000) ? 32'h8000_0000 : 32'(32'd0 - q[31:0]);
    return (q > 128'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
  endfunction

endpackage

>>> src/mi_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mi_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module mi_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

>>> src/mi_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mi_mul
// Shared 33x33 signed multiplier with registered product.
// ----------------------------------------------------------------------------
module mi_mul (
  input  logic               clk,
  input  logic signed [32:0] a,
  input  logic signed [32:0] b,
  output logic signed [65:0] p
);

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

>>> src/mi_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mi_div
// Unsigned 128-bit restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mi_div (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [127:0] num,
  input  logic [127:0] den,
  output logic         done,
  output logic [127:0] quot
);

  logic         running;
  logic [6:0]   count;
  logic [127:0] rem;
  logic [127:0] dvs;
  logic [128:0] shifted;
  logic [128:0] diff;

  assign shifted = {rem, quot[127]};
  assign diff    = shifted - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      count   <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        count   <= '1;
      end else if (running) begin
        count <= count - 7'd1;
        if (count == '0) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  // quotient register doubles as the numerator shift register
  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      dvs  <= den;
      quot <= num;
    end else if (running) begin
      if (!diff[128]) begin
        rem  <= diff[127:0];
        quot <= {quot[126:0], 1'b1};
      end else begin
        rem  <= shifted[127:0];
        quot <= {quot[126:0], 1'b0};
      end
    end
  end

endmodule

>>> src/morans_i_statistic_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// morans_i_statistic_top
// Moran's I spatial autocorrelation over a loaded response set, Q16.16.
// ----------------------------------------------------------------------------
// Usage: write n_obs through cfg_write/cfg_data while idle. Send items with
// start; a transfer happens when start is high and busy is low.
// A load item (command 0) writes sample_value at row_index when that index
// is below MAX_OBS; busy stays low. Weight items (command 1) skip the store
// reads and multiplies when an index is out of range. The first weight item
// of a data set also runs the mean division on the shared divider and the
// squared deviation walk, one observation at a time through the single
// store read port and shared multiplier.
// The last item then runs 6 multiplier passes and, unless a status error is
// flagged, a division; result appears with done high for exactly one cycle;
// the receiver cannot stall, so it must take it then. Status 2 flags a
// response count that differs from n_obs, 1 a zero denominator.
// Reset clears all accumulators and sets n_obs to 1; the response store is
// not cleared and holds garbage until loaded.
// ----------------------------------------------------------------------------
module morans_i_statistic_top #(
  parameter int MAX_OBS = 1024
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  mi_pkg::item_in_t    request,
  output logic                busy,
  input  logic                cfg_write,
  input  logic [10:0]         cfg_data,
  output logic                done,
  output mi_pkg::item_out_t   result
);

  import mi_pkg::*;

  localparam int AW = $clog2(MAX_OBS);

  state_t state, state_next;

  logic [10:0]  n_obs;
  logic [10:0]  n;
  item_in_t     item;
  logic [63:0]  response_sum;
  logic [10:0]  responses_loaded;
  logic [31:0]  mean_value;
  logic [63:0]  cross_sum;
  logic [63:0]  weight_sum;
  logic [63:0]  square_sum;
  logic         mean_ready;
  logic [11:0]  k;
  logic [31:0]  dev_a, dev_b, t_val;
  logic [127:0] num, den;
  logic [2:0]   fin_step;
  logic [31:0]  stat_r;
  logic [1:0]   status_r;

  logic         ram_we, load_ok, in_range;
  logic [AW-1:0] raddr;
  logic [31:0]  rdata;
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod;
  logic [63:0]  prod_q;
  logic         div_start, div_done;
  logic [127:0] div_num, div_den, quot;
  logic [63:0]  mag_c, mag_w, mag_s;
  logic [127:0] p128;

  always_comb begin
    if (n_obs == '0) n = 11'd1;
    else if (18'(n_obs) > 18'(MAX_OBS)) n = 11'(MAX_OBS);
    else n = n_obs;
  end

  assign load_ok  = 18'(request.row_index) < 18'(MAX_OBS);
  assign in_range = ({1'b0, item.row_index} < n) && ({1'b0, item.col_index} < n);
  assign prod_q   = 64'(prod >>> 16);
  assign mag_c    = mag64(cross_sum);
  assign mag_w    = mag64(weight_sum);
  assign mag_s    = mag64(square_sum);
  assign p128     = 128'(prod[63:0]);

  mi_ram #(.WIDTH(32), .DEPTH(MAX_OBS)) u_store (
    .clk(clk), .we(ram_we), .waddr(AW'(request.row_index)),
    .wdata(request.sample_value), .raddr(raddr), .rdata(rdata)
  );

  mi_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(prod));

  mi_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num), .den(div_den),
    .done(div_done), .quot(quot)
  );

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    busy       = (state != S_IDLE);
    done       = (state == S_OUT);
    ram_we     = 1'b0;
    raddr      = AW'(item.row_index);
    mul_a      = '0;
    mul_b      = '0;
    div_start  = 1'b0;
    div_num    = num;
    div_den    = den;
    case (state)
      S_IDLE: begin
        div_num = 128'(mag64(response_sum));
        div_den = 128'(n);
        if (start) begin
          if (request.command == CMD_LOAD) begin
            ram_we = load_ok;
          end else if (mean_ready) begin
            state_next = S_W_CHK;
          end else begin
            div_start  = 1'b1;
            state_next = S_MEAN_DIV;
          end
        end
      end
      S_MEAN_DIV: if (div_done) state_next = S_MEAN_SET;
      S_MEAN_SET: state_next = S_SQ_RD;
      S_SQ_RD: begin
        raddr      = AW'(k);
        state_next = S_SQ_DEV;
      end
      S_SQ_DEV: state_next = S_SQ_MUL;
      S_SQ_MUL: begin
        mul_a      = {dev_a[31], dev_a};
        mul_b      = {dev_a[31], dev_a};
        state_next = S_SQ_ACC;
      end
      S_SQ_ACC: state_next = (k + 12'd1 == 12'(n)) ? S_W_CHK : S_SQ_RD;
      S_W_CHK: begin
        if (in_range) state_next = S_W_RDI;
        else if (item.last) state_next = S_FIN_MUL;
        else state_next = S_IDLE;
      end
      S_W_RDI: begin
        raddr      = AW'(item.col_index);
        state_next = S_W_RDJ;
      end
      S_W_RDJ: begin
        mul_a      = {item.sample_value[31], item.sample_value};
        mul_b      = {dev_a[31], dev_a};
        state_next = S_W_T;
      end
      S_W_T: state_next = S_W_MUL2;
      S_W_MUL2: begin
        mul_a      = {t_val[31], t_val};
        mul_b      = {dev_b[31], dev_b};
        state_next = S_W_ACC;
      end
      S_W_ACC: state_next = item.last ? S_FIN_MUL : S_IDLE;
      S_FIN_MUL: begin
        case (fin_step)
          3'd0: begin mul_a = {1'b0, mag_c[31:0]};  mul_b = 33'(n); end
          3'd1: begin mul_a = {1'b0, mag_c[63:32]}; mul_b = 33'(n); end
          3'd2: begin mul_a = {1'b0, mag_w[31:0]};  mul_b = {1'b0, mag_s[31:0]}; end
          3'd3: begin mul_a = {1'b0, mag_w[31:0]};  mul_b = {1'b0, mag_s[63:32]}; end
          3'd4: begin mul_a = {1'b0, mag_w[63:32]}; mul_b = {1'b0, mag_s[31:0]}; end
          3'd5: begin mul_a = {1'b0, mag_w[63:32]}; mul_b = {1'b0, mag_s[63:32]}; end
          default: state_next = S_FIN_CHK;
        endcase
      end
      S_FIN_CHK: begin
        if (responses_loaded != n_obs || den == '0) begin
          state_next = S_OUT;
        end else begin
          div_start  = 1'b1;
          state_next = S_FIN_DIV;
        end
      end
      S_FIN_DIV: if (div_done) state_next = S_OUT;
      S_OUT: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // control and accumulator state
  always_ff @(posedge clk) begin
    if (rst) begin
      n_obs            <= 11'd1;
      response_sum     <= '0;
      responses_loaded <= '0;
      mean_value       <= '0;
      cross_sum        <= '0;
      weight_sum       <= '0;
      square_sum       <= '0;
      mean_ready       <= 1'b0;
    end else begin
      if (cfg_write) n_obs <= cfg_data;
      case (state)
        S_IDLE: begin
          if (start && request.command == CMD_LOAD && load_ok) begin
            response_sum <= sat_add64(response_sum, 64'(request.sample_value));
            if (responses_loaded != '1) responses_loaded <= responses_loaded + 11'd1;
          end
        end
        S_MEAN_DIV: if (div_done) mean_value <= sign_sat(quot, response_sum[63]);
        S_MEAN_SET: begin
          square_sum <= '0;
          mean_ready <= 1'b1;
        end
        S_SQ_ACC: square_sum <= sat_add64(square_sum, prod_q);
        S_W_ACC: begin
          cross_sum  <= sat_add64(cross_sum, prod_q);
          weight_sum <= sat_add64(weight_sum, 64'(item.sample_value));
        end
        S_OUT: begin
          response_sum     <= '0;
          responses_loaded <= '0;
          mean_value       <= '0;
          cross_sum        <= '0;
          weight_sum       <= '0;
          square_sum       <= '0;
          mean_ready       <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) item <= request;
    case (state)
      S_MEAN_SET: k <= '0;
      S_SQ_DEV:   dev_a <= deviate(rdata, mean_value);
      S_SQ_ACC:   k <= k + 12'd1;
      S_W_CHK: begin
        fin_step <= '0;
        num      <= '0;
        den      <= '0;
      end
      S_W_RDI:    dev_a <= deviate(rdata, mean_value);
      S_W_RDJ:    dev_b <= deviate(rdata, mean_value);
      S_W_T:      t_val <= sat32(prod_q);
      S_FIN_MUL: begin
        fin_step <= fin_step + 3'd1;
        // product of the previous step lands here
        case (fin_step)
          3'd1: num <= num + (p128 << 32);
          3'd2: num <= num + (p128 << 64);
          3'd3: den <= den + p128;
          3'd4: den <= den + (p128 << 32);
          3'd5: den <= den + (p128 << 32);
          3'd6: den <= den + (p128 << 64);
          default: ;
        endcase
      end
      S_FIN_CHK: begin
        stat_r <= '0;
        if (responses_loaded != n_obs) status_r <= STATUS_COUNT;
        else if (den == '0) status_r <= STATUS_ZERO_DEN;
        else status_r <= STATUS_OK;
      end
      S_FIN_DIV: if (div_done) stat_r <= sign_sat(quot, cross_sum[63] != weight_sum[63]);
      default: ;
    endcase
  end

  assign result.statistic = stat_r;
  assign result.status    = status_r;

  a_done_then_idle: assert property (@(posedge clk) disable iff (rst)
    done |=> !busy) else $error("block not idle after result");

  a_bad_status_zero: assert property (@(posedge clk) disable iff (rst)
    done && result.status != STATUS_OK |-> result.statistic == '0)
    else $error("statistic nonzero with error status");

  a_load_one_cycle: assert property (@(posedge clk) disable iff (rst)
    start && !busy && request.command == CMD_LOAD |=> !busy)
    else $error("load transfer left block busy");

  a_mean_before_weights: assert property (@(posedge clk) disable iff (rst)
    state == S_W_RDI |-> mean_ready) else $error("weight pass without mean");

endmodule
